@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on the rising edge, disabled while reset is low.
`define SPIC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("segment pair classifier: assertion failed");

// Same, but also checked while reset is asserted.
`define SPIC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("segment pair classifier: assertion failed");

`endif

@@ rtl/spic_pkg.sv @@
// Types and codes shared by the segment pair classifier.
`default_nettype none

package spic_pkg;

  // Relation codes of a result item.
  typedef enum logic [1:0] {
    REL_NONE      = 2'd0,
    REL_INTERSECT = 2'd1,
    REL_CONTAIN   = 2'd2
  } relation_e;

  // Number of orientation tests per pair.
  localparam int unsigned NumOrient = 4;

  // Number of coordinate differences feeding the products.
  localparam int unsigned NumDiff = 12;

  // Outcome of the collinear range tests, carried alongside the arithmetic.
  typedef struct packed {
    logic overlap;
    logic contain;
  } coll_t;

  // Sign of each orientation: order is first-vs-second-start, first-vs-second-end,
  // second-vs-first-start, second-vs-first-end.
  typedef struct packed {
    logic [NumOrient-1:0] neg;
    logic [NumOrient-1:0] zero;
  } orient_t;

endpackage

`default_nettype wire

@@ rtl/spic_if.sv @@
// Handshake channels of the segment pair classifier.
`default_nettype none

interface spic_in_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_start_x;
  logic signed [COORD_WIDTH-1:0] first_start_y;
  logic signed [COORD_WIDTH-1:0] first_end_x;
  logic signed [COORD_WIDTH-1:0] first_end_y;
  logic signed [COORD_WIDTH-1:0] second_start_x;
  logic signed [COORD_WIDTH-1:0] second_start_y;
  logic signed [COORD_WIDTH-1:0] second_end_x;
  logic signed [COORD_WIDTH-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );

  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

interface spic_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] relation;

  modport source (output valid, relation, input ready);
  modport sink (input valid, relation, output ready);
endinterface

`default_nettype wire

@@ rtl/spic_prep.sv @@
// Difference stage: coordinate differences and the collinear range tests.
`default_nettype none

module spic_prep
  import spic_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic signed [COORD_WIDTH-1:0] a0x_i,
  input  wire logic signed [COORD_WIDTH-1:0] a0y_i,
  input  wire logic signed [COORD_WIDTH-1:0] a1x_i,
  input  wire logic signed [COORD_WIDTH-1:0] a1y_i,
  input  wire logic signed [COORD_WIDTH-1:0] b0x_i,
  input  wire logic signed [COORD_WIDTH-1:0] b0y_i,
  input  wire logic signed [COORD_WIDTH-1:0] b1x_i,
  input  wire logic signed [COORD_WIDTH-1:0] b1y_i,
  output logic signed [COORD_WIDTH:0]        diff_o [NumDiff],
  output coll_t                              coll_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;

  logic signed [DW-1:0] diff_d [NumDiff];
  logic signed [DW-1:0] diff_q [NumDiff];
  coll_t                coll_d;
  coll_t                coll_q;

  logic signed [COORD_WIDTH-1:0] alx, aly, ahx, ahy, blx, bly, bhx, bhy;
  logic                          swap_a, swap_b;

  function automatic logic signed [DW-1:0] sub(input logic signed [COORD_WIDTH-1:0] l,
                                               input logic signed [COORD_WIDTH-1:0] r);
    sub = $signed({l[COORD_WIDTH-1], l}) - $signed({r[COORD_WIDTH-1], r});
  endfunction

  // Lexicographic less-or-equal: x first, then y.
  function automatic logic lex_le(input logic signed [COORD_WIDTH-1:0] lx,
                                  input logic signed [COORD_WIDTH-1:0] ly,
                                  input logic signed [COORD_WIDTH-1:0] rx,
                                  input logic signed [COORD_WIDTH-1:0] ry);
    lex_le = (lx == rx) ? (ly <= ry) : (lx <= rx);
  endfunction

  always_comb begin
    diff_d[0]  = sub(a1x_i, a0x_i);
    diff_d[1]  = sub(a1y_i, a0y_i);
    diff_d[2]  = sub(b0x_i, a0x_i);
    diff_d[3]  = sub(b0y_i, a0y_i);
    diff_d[4]  = sub(b1x_i, a0x_i);
    diff_d[5]  = sub(b1y_i, a0y_i);
    diff_d[6]  = sub(b1x_i, b0x_i);
    diff_d[7]  = sub(b1y_i, b0y_i);
    diff_d[8]  = sub(a0x_i, b0x_i);
    diff_d[9]  = sub(a0y_i, b0y_i);
    diff_d[10] = sub(a1x_i, b0x_i);
    diff_d[11] = sub(a1y_i, b0y_i);
  end

  // Put each segment's endpoints in lexicographic order before the range tests.
  always_comb begin
    swap_a = lex_le(a1x_i, a1y_i, a0x_i, a0y_i);
    swap_b = lex_le(b1x_i, b1y_i, b0x_i, b0y_i);
    alx = swap_a ? a1x_i : a0x_i;
    aly = swap_a ? a1y_i : a0y_i;
    ahx = swap_a ? a0x_i : a1x_i;
    ahy = swap_a ? a0y_i : a1y_i;
    blx = swap_b ? b1x_i : b0x_i;
    bly = swap_b ? b1y_i : b0y_i;
    bhx = swap_b ? b0x_i : b1x_i;
    bhy = swap_b ? b0y_i : b1y_i;
    coll_d.overlap = lex_le(blx, bly, ahx, ahy) && lex_le(alx, aly, bhx, bhy);
    coll_d.contain = (alx <= blx) && (aly <= bly) && (ahx >= bhx) && (ahy >= bhy);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q <= diff_d;
      coll_q <= coll_d;
    end
  end

  assign diff_o = diff_q;
  assign coll_o = coll_q;

endmodule

`default_nettype wire

@@ rtl/spic_prod.sv @@
// Product stage: the eight cross-product terms of the four orientations.
`default_nettype none

module spic_prod
  import spic_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [COORD_WIDTH:0]       diff_i [NumDiff],
  input  wire coll_t                             coll_i,
  output logic signed [2*COORD_WIDTH+1:0]        prod_o [2*NumOrient],
  output coll_t                                  coll_o
);

  localparam int unsigned PW = 2 * (COORD_WIDTH + 1);

  logic signed [PW-1:0] prod_d [2*NumOrient];
  logic signed [PW-1:0] prod_q [2*NumOrient];
  coll_t                coll_q;

  // Even entries are the left term of an orientation, odd entries the right one.
  always_comb begin
    prod_d[0] = diff_i[0] * diff_i[3];
    prod_d[1] = diff_i[1] * diff_i[2];
    prod_d[2] = diff_i[0] * diff_i[5];
    prod_d[3] = diff_i[1] * diff_i[4];
    prod_d[4] = diff_i[6] * diff_i[9];
    prod_d[5] = diff_i[7] * diff_i[8];
    prod_d[6] = diff_i[6] * diff_i[11];
    prod_d[7] = diff_i[7] * diff_i[10];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      coll_q <= coll_i;
    end
  end

  assign prod_o = prod_q;
  assign coll_o = coll_q;

endmodule

`default_nettype wire

@@ rtl/spic_sign.sv @@
// Sign stage: subtracts each product pair and keeps the sign of the orientation.
`default_nettype none

module spic_sign
  import spic_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic signed [2*COORD_WIDTH+1:0] prod_i [2*NumOrient],
  input  wire coll_t                         coll_i,
  output orient_t                            orient_o,
  output coll_t                              coll_o
);

  localparam int unsigned PW = 2 * (COORD_WIDTH + 1);
  localparam int unsigned SW = PW + 1;

  logic signed [SW-1:0] det [NumOrient];
  orient_t              orient_d;
  orient_t              orient_q;
  coll_t                coll_q;

  always_comb begin
    for (int k = 0; k < NumOrient; k++) begin
      det[k] = $signed({prod_i[2*k][PW-1], prod_i[2*k]})
             - $signed({prod_i[2*k+1][PW-1], prod_i[2*k+1]});
      orient_d.neg[k]  = det[k][SW-1];
      orient_d.zero[k] = (prod_i[2*k] == prod_i[2*k+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      orient_q <= orient_d;
      coll_q   <= coll_i;
    end
  end

  assign orient_o = orient_q;
  assign coll_o   = coll_q;

endmodule

`default_nettype wire

@@ rtl/segment_pair_intersection_classify.sv @@
// Top level of the segment pair classifier: input register, pipeline control, result stage.
//
// One item on in_i carries two segments, each as start and end point in signed
// coordinates of COORD_WIDTH bits. For each item one result item leaves on out_o,
// holding the relation: none, intersecting, or first contains second.
// Items leave in the order they arrive.
//
// The pipeline has five register stages: input capture, coordinate differences
// with the collinear range tests, the eight cross products, the orientation
// signs, and the result register that drives out_o. A result is offered on out_o
// once its item has moved through the input, difference, product and sign
// registers into the result register; one item is taken in every cycle while the
// receiver keeps out_o.ready high. The multiplier stage sets the clock period.
//
// Each stage holds a valid bit and advances when the stage after it is empty or
// advancing, so when the receiver holds ready low the result stays on out_o
// unchanged and the stages behind it keep filling any empty slots; in_i.ready
// falls only once all five stages hold items. Reset empties every stage.
`default_nettype none

module segment_pair_intersection_classify
  import spic_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spic_in_if.sink   in_i,
  spic_out_if.source out_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic v1_d, v2_d, v3_d, v4_d, v5_d;
  logic en1, en2, en3, en4, en5;

  logic signed [COORD_WIDTH-1:0] a0x_q, a0y_q, a1x_q, a1y_q;
  logic signed [COORD_WIDTH-1:0] b0x_q, b0y_q, b1x_q, b1y_q;

  logic signed [DW-1:0] diff [NumDiff];
  logic signed [PW-1:0] prod [2*NumOrient];
  coll_t                coll2, coll3, coll4;
  orient_t              orient4;

  logic      pa_zero, pb_zero, pa_neg, pb_neg;
  relation_e rel_d, rel_q;

  // A stage may load when it is empty or its item moves on in the same cycle.
  assign en5 = !v5_q || out_o.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign v1_d = en1 ? in_i.valid : v1_q;
  assign v2_d = en2 ? v1_q : v2_q;
  assign v3_d = en3 ? v2_q : v3_q;
  assign v4_d = en4 ? v3_q : v4_q;
  assign v5_d = en5 ? v4_q : v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
      v5_q <= v5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      a0x_q <= in_i.first_start_x;
      a0y_q <= in_i.first_start_y;
      a1x_q <= in_i.first_end_x;
      a1y_q <= in_i.first_end_y;
      b0x_q <= in_i.second_start_x;
      b0y_q <= in_i.second_start_y;
      b1x_q <= in_i.second_end_x;
      b1y_q <= in_i.second_end_y;
    end
  end

  spic_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
    .clk_i  (clk_i),
    .en_i   (en2),
    .a0x_i  (a0x_q),
    .a0y_i  (a0y_q),
    .a1x_i  (a1x_q),
    .a1y_i  (a1y_q),
    .b0x_i  (b0x_q),
    .b0y_i  (b0y_q),
    .b1x_i  (b1x_q),
    .b1y_i  (b1y_q),
    .diff_o (diff),
    .coll_o (coll2)
  );

  spic_prod #(.COORD_WIDTH(COORD_WIDTH)) u_prod (
    .clk_i  (clk_i),
    .en_i   (en3),
    .diff_i (diff),
    .coll_i (coll2),
    .prod_o (prod),
    .coll_o (coll3)
  );

  spic_sign #(.COORD_WIDTH(COORD_WIDTH)) u_sign (
    .clk_i    (clk_i),
    .en_i     (en4),
    .prod_i   (prod),
    .coll_i   (coll3),
    .orient_o (orient4),
    .coll_o   (coll4)
  );

  // A product of two orientation signs is zero if either is zero, and negative
  // when both are non-zero and differ.
  always_comb begin
    pa_zero = orient4.zero[0] || orient4.zero[1];
    pb_zero = orient4.zero[2] || orient4.zero[3];
    pa_neg  = !pa_zero && (orient4.neg[0] ^ orient4.neg[1]);
    pb_neg  = !pb_zero && (orient4.neg[2] ^ orient4.neg[3]);
    if (pa_zero && pb_zero) begin
      if (!coll4.overlap) begin
        rel_d = REL_NONE;
      end else if (coll4.contain) begin
        rel_d = REL_CONTAIN;
      end else begin
        rel_d = REL_INTERSECT;
      end
    end else if (pa_neg && pb_neg) begin
      rel_d = REL_INTERSECT;
    end else begin
      rel_d = REL_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      rel_q <= rel_d;
    end
  end

  assign in_i.ready     = en1;
  assign out_o.valid    = v5_q;
  assign out_o.relation = rel_q;

endmodule

`default_nettype wire

@@ rtl/spic_checker.sv @@
// Port-level checker for the segment pair classifier and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module spic_checker
  import spic_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [1:0] relation_i
);

  // A stalled result stays offered and unchanged.
  `SPIC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  `SPIC_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(relation_i))

  // The unused relation code never leaves the block.
  `SPIC_ASSERT(a_rel_code, clk_i, rst_ni,
               out_valid_i |-> (relation_i == REL_NONE || relation_i == REL_INTERSECT ||
                                relation_i == REL_CONTAIN))

  // With the result register empty the whole pipeline can advance, so input is taken.
  `SPIC_ASSERT_ALWAYS(a_ready_when_empty, clk_i, !out_valid_i |-> in_ready_i)

  // With the receiver ready throughout, an accepted item is offered on out_o after passing every pipeline register.
  `SPIC_ASSERT(a_latency, clk_i, rst_ni,
               (in_valid_i && in_ready_i) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
               ##1 out_ready_i |=> out_valid_i)

endmodule

bind segment_pair_intersection_classify spic_checker u_spic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .relation_i  (out_o.relation)
);

`default_nettype wire
